// ===== rtl/frr_pkg.sv =====
`timescale 1ns / 1ps

package frr_pkg;

  localparam int COS_FRAC_BITS   = 30;
  localparam int INDEX_FRAC_BITS = 16;
  localparam int IDX_W           = INDEX_FRAC_BITS + 2;
  localparam int COS_W           = COS_FRAC_BITS + 1;
  localparam int CODE_W          = 3;
  localparam int ADDR_W          = 3;
  localparam int DATA_W          = 32;

  localparam logic [COS_W-1:0] COS_ONE = {1'b1, {COS_FRAC_BITS{1'b0}}};

  // case codes
  localparam logic [CODE_W-1:0] CASE_MATCHED = 3'd0;
  localparam logic [CODE_W-1:0] CASE_NORMAL  = 3'd1;
  localparam logic [CODE_W-1:0] CASE_GRAZING = 3'd2;
  localparam logic [CODE_W-1:0] CASE_TIR     = 3'd3;
  localparam logic [CODE_W-1:0] CASE_GENERAL = 3'd4;

  // register select, paddr bit 2
  localparam logic REG_NORMAL  = 1'b0;
  localparam logic REG_GRAZING = 1'b1;

  localparam logic [COS_W-1:0] NORMAL_THR_RESET  = 31'd1073741823;
  localparam logic [COS_W-1:0] GRAZING_THR_RESET = 31'd1074;

  typedef struct packed {
    logic [IDX_W-1:0] index_incident;
    logic [IDX_W-1:0] index_transmit;
    logic [COS_W-1:0] cos_incident;
  } req_t;

  typedef struct packed {
    logic [COS_W-1:0]  reflectance;
    logic [COS_W-1:0]  cos_transmit;
    logic [CODE_W-1:0] case_code;
  } rsp_t;

  typedef struct packed {
    logic [COS_W-1:0] normal_cos_threshold;
    logic [COS_W-1:0] grazing_cos_threshold;
  } cfg_t;

endpackage

// ===== rtl/frr_datapath.sv =====
`timescale 1ns / 1ps

module frr_datapath import frr_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic en,
  input  cfg_t cfg,
  input  logic req_valid,
  input  req_t req_data,
  output logic rsp_valid,
  output rsp_t rsp_data
);

  localparam int SQ_N   = COS_W;
  localparam int RAD_W  = 2 * SQ_N;
  localparam int REM_W  = COS_FRAC_BITS + 4;
  localparam int PROD_W = IDX_W + COS_W;
  localparam int DV1_N  = COS_FRAC_BITS;
  localparam int SUM_W  = PROD_W + 1;
  localparam int DREM_W = SUM_W + 1;
  localparam int DV2_N  = COS_W;
  localparam int SQR_W  = COS_W + 1;

  localparam logic [RAD_W-1:0] ONE_SQ = RAD_W'(1) << (2 * COS_FRAC_BITS);

  typedef struct packed {
    logic [IDX_W-1:0]  n1;
    logic [IDX_W-1:0]  n2;
    logic [COS_W-1:0]  c1;
    logic [CODE_W-1:0] code;
    logic [COS_W-1:0]  c2;
  } sb_t;

  typedef struct packed {
    logic [RAD_W-1:0] rad;
    logic [REM_W-1:0] rem;
    logic [COS_W-1:0] root;
  } sq_t;

  typedef struct packed {
    logic [PROD_W-1:0] rem;
    logic [DV1_N-1:0]  q;
  } dv1_t;

  typedef struct packed {
    logic [DREM_W-1:0] rem;
    logic [SUM_W-1:0]  sum;
    logic [COS_W-1:0]  q;
    logic              zero;
  } dv2_t;

  // one root bit per step
  function automatic sq_t sq_step(input sq_t s);
    sq_t o;
    logic [REM_W-1:0] remx;
    logic [REM_W-1:0] trial;
    remx  = {s.rem[REM_W-3:0], s.rad[RAD_W-1 -: 2]};
    trial = REM_W'({s.root, 2'b01});
    o.rad = s.rad << 2;
    if (remx >= trial) begin
      o.rem  = remx - trial;
      o.root = {s.root[COS_W-2:0], 1'b1};
    end else begin
      o.rem  = remx;
      o.root = {s.root[COS_W-2:0], 1'b0};
    end
    return o;
  endfunction

  // quotient bit b of n1*s1 / n2
  function automatic dv1_t dv1_step(input dv1_t d, input logic [IDX_W-1:0] n2, input int b);
    dv1_t o;
    logic [PROD_W-1:0] dsh;
    dsh = PROD_W'(n2) << b;
    if (d.rem >= dsh) begin
      o.rem = d.rem - dsh;
      o.q   = {d.q[DV1_N-2:0], 1'b1};
    end else begin
      o.rem = d.rem;
      o.q   = {d.q[DV1_N-2:0], 1'b0};
    end
    return o;
  endfunction

  // one bit of diff * 2^frac / sum, diff never above sum
  function automatic dv2_t dv2_step(input dv2_t d, input logic first);
    dv2_t o;
    logic [DREM_W-1:0] r;
    logic [DREM_W-1:0] s;
    r = first ? d.rem : {d.rem[DREM_W-2:0], 1'b0};
    s = DREM_W'(d.sum);
    o = d;
    if (r >= s) begin
      o.rem = r - s;
      o.q   = {d.q[COS_W-2:0], 1'b1};
    end else begin
      o.rem = r;
      o.q   = {d.q[COS_W-2:0], 1'b0};
    end
    return o;
  endfunction

  // input stage: saturate and classify
  logic              s0_vld;
  sb_t               s0_sb;
  logic [COS_W-1:0]  c1_sat;
  logic [CODE_W-1:0] code0;

  always_comb begin
    c1_sat = (req_data.cos_incident > COS_ONE) ? COS_ONE : req_data.cos_incident;
    priority if (req_data.index_incident == req_data.index_transmit) begin
      code0 = CASE_MATCHED;
    end else if (c1_sat > cfg.normal_cos_threshold) begin
      code0 = CASE_NORMAL;
    end else if (c1_sat < cfg.grazing_cos_threshold) begin
      code0 = CASE_GRAZING;
    end else begin
      code0 = CASE_GENERAL;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s0_vld <= 1'b0;
    end else if (en) begin
      s0_vld <= req_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s0_sb <= '{n1: req_data.index_incident, n2: req_data.index_transmit,
                 c1: c1_sat, code: code0, c2: '0};
    end
  end

  // c1 squared
  logic             s1_vld;
  sb_t              s1_sb;
  logic [RAD_W-1:0] s1_csq;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_vld <= 1'b0;
    end else if (en) begin
      s1_vld <= s0_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_sb  <= s0_sb;
      s1_csq <= s0_sb.c1 * s0_sb.c1;
    end
  end

  // s1 = sqrt(1 - c1^2)
  logic sqa_vld [SQ_N+1];
  sb_t  sqa_sb  [SQ_N+1];
  sq_t  sqa     [SQ_N+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      sqa_vld[0] <= 1'b0;
    end else if (en) begin
      sqa_vld[0] <= s1_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sqa_sb[0] <= s1_sb;
      sqa[0]    <= '{rad: ONE_SQ - s1_csq, rem: '0, root: '0};
    end
  end

  for (genvar k = 0; k < SQ_N; k++) begin : g_sqa
    always_ff @(posedge clk) begin
      if (rst) begin
        sqa_vld[k+1] <= 1'b0;
      end else if (en) begin
        sqa_vld[k+1] <= sqa_vld[k];
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        sqa_sb[k+1] <= sqa_sb[k];
        sqa[k+1]    <= sq_step(sqa[k]);
      end
    end
  end

  // n1 * s1
  logic              p_vld;
  sb_t               p_sb;
  logic [PROD_W-1:0] p_prod;

  always_ff @(posedge clk) begin
    if (rst) begin
      p_vld <= 1'b0;
    end else if (en) begin
      p_vld <= sqa_vld[SQ_N];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p_sb   <= sqa_sb[SQ_N];
      p_prod <= sqa_sb[SQ_N].n1 * sqa[SQ_N].root;
    end
  end

  // total internal reflection test, then s2 = n1*s1/n2
  logic tir;
  sb_t  t_sb;
  logic dv1_vld [DV1_N+1];
  sb_t  dv1_sb  [DV1_N+1];
  dv1_t dv1     [DV1_N+1];

  always_comb begin
    tir  = (p_sb.n2 == '0) || (p_prod >= (PROD_W'(p_sb.n2) << COS_FRAC_BITS));
    t_sb = p_sb;
    if (p_sb.code == CASE_GENERAL && tir) begin
      t_sb.code = CASE_TIR;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dv1_vld[0] <= 1'b0;
    end else if (en) begin
      dv1_vld[0] <= p_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dv1_sb[0] <= t_sb;
      dv1[0]    <= '{rem: p_prod, q: '0};
    end
  end

  for (genvar k = 0; k < DV1_N; k++) begin : g_dv1
    always_ff @(posedge clk) begin
      if (rst) begin
        dv1_vld[k+1] <= 1'b0;
      end else if (en) begin
        dv1_vld[k+1] <= dv1_vld[k];
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        dv1_sb[k+1] <= dv1_sb[k];
        dv1[k+1]    <= dv1_step(dv1[k], dv1_sb[k].n2, DV1_N - 1 - k);
      end
    end
  end

  // s2 squared
  logic             m_vld;
  sb_t              m_sb;
  logic [RAD_W-1:0] m_sq;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_vld <= 1'b0;
    end else if (en) begin
      m_vld <= dv1_vld[DV1_N];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m_sb <= dv1_sb[DV1_N];
      m_sq <= dv1[DV1_N].q * dv1[DV1_N].q;
    end
  end

  // c2 = sqrt(1 - s2^2)
  logic sqb_vld [SQ_N+1];
  sb_t  sqb_sb  [SQ_N+1];
  sq_t  sqb     [SQ_N+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      sqb_vld[0] <= 1'b0;
    end else if (en) begin
      sqb_vld[0] <= m_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sqb_sb[0] <= m_sb;
      sqb[0]    <= '{rad: ONE_SQ - m_sq, rem: '0, root: '0};
    end
  end

  for (genvar k = 0; k < SQ_N; k++) begin : g_sqb
    always_ff @(posedge clk) begin
      if (rst) begin
        sqb_vld[k+1] <= 1'b0;
      end else if (en) begin
        sqb_vld[k+1] <= sqb_vld[k];
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        sqb_sb[k+1] <= sqb_sb[k];
        sqb[k+1]    <= sq_step(sqb[k]);
      end
    end
  end

  // amplitude terms, lane 0 is rs, lane 1 is rp
  logic              x_vld;
  sb_t               x_sb;
  sb_t               x_sb_next;
  logic [PROD_W-1:0] x_a      [2];
  logic [PROD_W-1:0] x_b      [2];
  logic [PROD_W-1:0] x_a_next [2];
  logic [PROD_W-1:0] x_b_next [2];

  always_comb begin
    x_sb_next    = sqb_sb[SQ_N];
    x_sb_next.c2 = sqb[SQ_N].root;
    x_a_next[1]  = x_sb_next.n2 * x_sb_next.c1;
    x_b_next[1]  = x_sb_next.n1 * x_sb_next.c2;
    if (x_sb_next.code == CASE_NORMAL) begin
      // normal incidence reuses lane 0 for the index ratio
      x_a_next[0] = PROD_W'(x_sb_next.n2);
      x_b_next[0] = PROD_W'(x_sb_next.n1);
    end else begin
      x_a_next[0] = x_sb_next.n1 * x_sb_next.c1;
      x_b_next[0] = x_sb_next.n2 * x_sb_next.c2;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      x_vld <= 1'b0;
    end else if (en) begin
      x_vld <= sqb_vld[SQ_N];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x_sb <= x_sb_next;
      x_a  <= x_a_next;
      x_b  <= x_b_next;
    end
  end

  // sum and difference, then the ratio division
  logic dv2_vld [DV2_N+1];
  sb_t  dv2_sb  [DV2_N+1];
  dv2_t dv2     [DV2_N+1][2];
  dv2_t y_init  [2];

  always_comb begin
    for (int l = 0; l < 2; l++) begin
      y_init[l].sum  = SUM_W'(x_a[l]) + SUM_W'(x_b[l]);
      y_init[l].rem  = (x_a[l] >= x_b[l]) ? DREM_W'(x_a[l] - x_b[l])
                                          : DREM_W'(x_b[l] - x_a[l]);
      y_init[l].q    = '0;
      y_init[l].zero = (y_init[l].sum == '0);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dv2_vld[0] <= 1'b0;
    end else if (en) begin
      dv2_vld[0] <= x_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dv2_sb[0] <= x_sb;
      dv2[0]    <= y_init;
    end
  end

  for (genvar k = 0; k < DV2_N; k++) begin : g_dv2
    always_ff @(posedge clk) begin
      if (rst) begin
        dv2_vld[k+1] <= 1'b0;
      end else if (en) begin
        dv2_vld[k+1] <= dv2_vld[k];
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        dv2_sb[k+1]  <= dv2_sb[k];
        dv2[k+1][0]  <= dv2_step(dv2[k][0], k == 0);
        dv2[k+1][1]  <= dv2_step(dv2[k][1], k == 0);
      end
    end
  end

  // squared amplitudes
  logic               q_vld;
  sb_t                q_sb;
  logic [SQR_W-1:0]   q_sq      [2];
  logic [SQR_W-1:0]   q_sq_next [2];
  logic [2*COS_W-1:0] q_prod    [2];

  always_comb begin
    for (int l = 0; l < 2; l++) begin
      q_prod[l]    = dv2[DV2_N][l].q * dv2[DV2_N][l].q;
      q_sq_next[l] = dv2[DV2_N][l].zero ? SQR_W'(COS_ONE)
                                        : q_prod[l][COS_FRAC_BITS +: SQR_W];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      q_vld <= 1'b0;
    end else if (en) begin
      q_vld <= dv2_vld[DV2_N];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      q_sb <= dv2_sb[DV2_N];
      q_sq <= q_sq_next;
    end
  end

  // result select and saturation
  logic [SQR_W:0]   r_sum;
  logic [SQR_W-1:0] r_pick;
  logic [COS_W-1:0] c2_pick;
  rsp_t             rsp_next;

  always_comb begin
    r_sum = {1'b0, q_sq[0]} + {1'b0, q_sq[1]};
    unique case (q_sb.code)
      CASE_MATCHED: begin
        r_pick  = '0;
        c2_pick = q_sb.c1;
      end
      CASE_NORMAL: begin
        r_pick  = q_sq[0];
        c2_pick = q_sb.c1;
      end
      CASE_GRAZING, CASE_TIR: begin
        r_pick  = SQR_W'(COS_ONE);
        c2_pick = '0;
      end
      default: begin
        r_pick  = r_sum[SQR_W:1];
        c2_pick = q_sb.c2;
      end
    endcase
    rsp_next.reflectance  = (r_pick > SQR_W'(COS_ONE)) ? COS_ONE : r_pick[COS_W-1:0];
    rsp_next.cos_transmit = c2_pick;
    rsp_next.case_code    = q_sb.code;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (en) begin
      rsp_valid <= q_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rsp_data <= rsp_next;
    end
  end

endmodule

// ===== rtl/fresnel_reflectance_top.sv =====
`timescale 1ns / 1ps

// Unpolarized Fresnel reflectance, fully pipelined: one request can be taken every
// cycle while req_stall is low, which it is unless the skid slot holds a result. The
// datapath chain is a 31-step square root for the incident sine, a 30-step divider
// for the transmitted sine, a second 31-step square root for the transmitted cosine
// and two 31-step ratio dividers running side by side, plus the multiply and setup
// stages between them and the output register. Indices are unsigned with 16
// fraction bits, cosines and reflectance with 30 (1.0 = 2^30). Thresholds live at
// APB byte address 0 (normal) and 4 (grazing) and should be written only while no
// request is in flight.

module fresnel_reflectance_top import frr_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready,
  input  logic              req_valid,
  output logic              req_stall,
  input  req_t              req_data,
  output logic              rsp_valid,
  input  logic              rsp_stall,
  output rsp_t              rsp_data
);

  // configuration registers
  cfg_t cfg;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.normal_cos_threshold  <= NORMAL_THR_RESET;
      cfg.grazing_cos_threshold <= GRAZING_THR_RESET;
    end else if (psel && penable && pwrite) begin
      unique case (paddr[2])
        REG_NORMAL:  cfg.normal_cos_threshold  <= pwdata[COS_W-1:0];
        REG_GRAZING: cfg.grazing_cos_threshold <= pwdata[COS_W-1:0];
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_NORMAL:  prdata = DATA_W'(cfg.normal_cos_threshold);
      REG_GRAZING: prdata = DATA_W'(cfg.grazing_cos_threshold);
    endcase
  end

  // the pipeline advances unless the skid slot is holding a result
  logic skid_vld;
  rsp_t skid_data;
  logic dp_vld;
  rsp_t dp_rsp;
  logic en;
  logic taken;

  assign en        = !skid_vld;
  assign req_stall = skid_vld;
  assign taken     = rsp_valid && !rsp_stall;

  frr_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .cfg       (cfg),
    .req_valid (req_valid),
    .req_data  (req_data),
    .rsp_valid (dp_vld),
    .rsp_data  (dp_rsp)
  );

  // output register plus one skid slot, so a waiting result does not freeze intake
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
      skid_vld  <= 1'b0;
    end else if (skid_vld) begin
      if (taken) begin
        skid_vld <= 1'b0;
      end
    end else if (dp_vld) begin
      if (!rsp_valid || taken) begin
        rsp_valid <= 1'b1;
      end else begin
        skid_vld <= 1'b1;
      end
    end else if (taken) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_vld) begin
      if (taken) begin
        rsp_data <= skid_data;
      end
    end else if (dp_vld) begin
      if (!rsp_valid || taken) begin
        rsp_data <= dp_rsp;
      end else begin
        skid_data <= dp_rsp;
      end
    end
  end

  // a held skid entry always sits behind a valid output
  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_vld |-> rsp_valid)
    else $error("skid entry without output entry");

  // a result arriving at a stalled output must land in the skid slot
  a_skid_catch: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp_stall && !skid_vld && dp_vld) |=> skid_vld)
    else $error("result lost at stalled output");

  // full reflection cases report unit reflectance and zero transmit cosine
  a_full_refl: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && (rsp_data.case_code == CASE_GRAZING || rsp_data.case_code == CASE_TIR))
    |-> (rsp_data.reflectance == COS_ONE && rsp_data.cos_transmit == '0))
    else $error("full reflection result malformed");

  a_refl_sat: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> (rsp_data.reflectance <= COS_ONE))
    else $error("reflectance above one");

endmodule

// ===== tb/sv/tb_fresnel_reflectance_top.sv =====
`timescale 1ns / 1ps

module tb_fresnel_reflectance_top;
  import frr_pkg::*;

  // pipeline depth used by wait_idle, which adds a margin for stalls
  localparam int LATENCY   = 134;
  localparam int N_RANDOM  = 1600;
  localparam longint CYCLE_LIMIT = 400000;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [DATA_W-1:0] pwdata = '0;
  logic [DATA_W-1:0] prdata;
  logic              pready;
  logic              req_valid = 1'b0;
  logic              req_stall;
  req_t              req_data = '0;
  logic              rsp_valid;
  logic              rsp_stall = 1'b0;
  rsp_t              rsp_data;

  fresnel_reflectance_top DUT (.*);

  always #4 clk = ~clk;

  // predictor copy of the thresholds
  logic [COS_W-1:0] thr_normal;
  logic [COS_W-1:0] thr_grazing;

  req_t request_q[$];
  rsp_t expected_q[$];
  int   fail_count = 0;
  longint cycle_count = 0;

  // truncated integer square root of a 128-bit value
  function automatic logic [63:0] isqrt128(input logic [127:0] a);
    logic [63:0]  root;
    logic [129:0] rem;
    logic [129:0] trial;
    root = '0;
    rem = '0;
    for (int i = 63; i >= 0; i--) begin
      rem = (rem << 2) | 130'(a[2*i +: 2]);
      trial = 130'({root, 2'b01});
      root = root << 1;
      if (rem >= trial) begin
        rem = rem - trial;
        root[0] = 1'b1;
      end
    end
    return root;
  endfunction

  // ((a-b)/(a+b))^2 in cosine format, 1.0 on a zero sum
  function automatic logic [63:0] amp_sq(input logic [63:0] a, input logic [63:0] b);
    logic [127:0] sum;
    logic [127:0] diff;
    logic [127:0] q;
    logic [127:0] sq;
    sum = 128'(a) + 128'(b);
    diff = (a >= b) ? 128'(a - b) : 128'(b - a);
    if (sum == 0) return 64'(COS_ONE);
    q = ((diff << COS_FRAC_BITS) / sum) & 128'hFFFF_FFFF_FFFF_FFFF;
    sq = q * q;
    return 64'(sq >> COS_FRAC_BITS);
  endfunction

  function automatic rsp_t fresnel_predict(input req_t rq);
    logic [63:0]  one;
    logic [63:0]  n1;
    logic [63:0]  n2;
    logic [63:0]  c1;
    logic [63:0]  c2;
    logic [63:0]  r;
    logic [63:0]  s1;
    logic [63:0]  s2;
    logic [127:0] one_sq;
    rsp_t         rs;
    one = 64'(COS_ONE);
    n1 = 64'(rq.index_incident);
    n2 = 64'(rq.index_transmit);
    c1 = 64'(rq.cos_incident);
    if (c1 > one) c1 = one;
    one_sq = 128'(one) * 128'(one);
    if (n1 == n2) begin
      r = '0; c2 = c1; rs.case_code = CASE_MATCHED;
    end else if (c1 > 64'(thr_normal)) begin
      r = amp_sq(n2, n1); c2 = c1; rs.case_code = CASE_NORMAL;
    end else if (c1 < 64'(thr_grazing)) begin
      r = one; c2 = '0; rs.case_code = CASE_GRAZING;
    end else begin
      s1 = isqrt128(one_sq - 128'(c1) * 128'(c1));
      s2 = (n2 == 0) ? one : (n1 * s1) / n2;
      if (s2 >= one) begin
        r = one; c2 = '0; rs.case_code = CASE_TIR;
      end else begin
        c2 = isqrt128(one_sq - 128'(s2) * 128'(s2));
        r = (amp_sq(n1 * c1, n2 * c2) + amp_sq(n2 * c1, n1 * c2)) >> 1;
        rs.case_code = CASE_GENERAL;
      end
    end
    if (r > one) r = one;
    rs.reflectance = r[COS_W-1:0];
    rs.cos_transmit = c2[COS_W-1:0];
    return rs;
  endfunction

  // acceptance seen at the rising edge
  logic req_taken = 1'b0;
  always @(posedge clk) begin
    req_taken <= req_valid && !req_stall && !rst;
    if (req_valid && !req_stall && !rst)
      expected_q.push_back(fresnel_predict(req_data));
  end

  // request driver: bursts with random gaps, payload held while stalled
  int burst_left = 0;
  int gap_left = 0;
  always @(negedge clk) begin
    if (!rst) begin
      if (!req_valid || req_taken) begin
        if (request_q.size() > 0 && gap_left == 0) begin
          req_data <= request_q.pop_front();
          req_valid <= 1'b1;
          if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 6);
          end else begin
            burst_left--;
          end
        end else begin
          req_valid <= 1'b0;
          if (gap_left > 0) gap_left--;
        end
      end
    end
  end

  // receiver stall pattern: phases of heavy, light and no stall
  int stall_mode = 0;
  int stall_phase = 0;
  always @(negedge clk) begin
    if (stall_phase == 0) begin
      stall_mode = $urandom_range(0, 2);
      stall_phase = $urandom_range(20, 200);
    end
    stall_phase--;
    case (stall_mode)
      0: rsp_stall <= 1'b0;
      1: rsp_stall <= ($urandom_range(0, 3) == 0);
      default: rsp_stall <= ($urandom_range(0, 3) != 0);
    endcase
  end

  // result monitor
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (!rst && rsp_valid && !rsp_stall) begin
      if (expected_q.size() == 0) begin
        $error("result with no request waiting: %h", rsp_data);
        fail_count++;
      end else begin
        rsp_t ex;
        ex = expected_q.pop_front();
        if (ex.reflectance !== rsp_data.reflectance) begin
          $error("reflectance expected %0d actual %0d", ex.reflectance, rsp_data.reflectance);
          fail_count++;
        end
        if (ex.cos_transmit !== rsp_data.cos_transmit) begin
          $error("cos_transmit expected %0d actual %0d",
                 ex.cos_transmit, rsp_data.cos_transmit);
          fail_count++;
        end
        if (ex.case_code !== rsp_data.case_code) begin
          $error("case_code expected %0d actual %0d", ex.case_code, rsp_data.case_code);
          fail_count++;
        end
      end
    end
  end

  // timeout guard
  always @(posedge clk) begin
    if (cycle_count > CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  task automatic apb_write(input logic sel, input logic [COS_W-1:0] value);
    @(negedge clk);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= ADDR_W'({sel, 2'b00}); pwdata <= DATA_W'(value);
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    if (sel == REG_NORMAL) thr_normal = value;
    else thr_grazing = value;
  endtask

  // waits for the block to drain before a register change
  task automatic wait_idle();
    while (request_q.size() > 0 || req_valid || expected_q.size() > 0) @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);
  endtask

  function automatic req_t make_req(input logic [IDX_W-1:0] a, input logic [IDX_W-1:0] b,
                                    input logic [COS_W-1:0] c);
    req_t rq;
    rq.index_incident = a;
    rq.index_transmit = b;
    rq.cos_incident = c;
    return rq;
  endfunction

  function automatic logic [IDX_W-1:0] rand_index();
    case ($urandom_range(0, 5))
      0: return IDX_W'(65536);
      1: return IDX_W'(262143);
      2: return IDX_W'($urandom_range(65536, 110000));
      default: return IDX_W'($urandom_range(65536, 262143));
    endcase
  endfunction

  function automatic logic [COS_W-1:0] rand_cos();
    case ($urandom_range(0, 7))
      0: return COS_W'($urandom_range(0, 4000));
      1: return COS_W'(COS_ONE - $urandom_range(0, 4000));
      2: return COS_W'($urandom_range(0, 32'h7FFF_FFFF));  // includes above one
      3: return COS_ONE;
      default: return COS_W'($urandom_range(0, 1073741824));
    endcase
  endfunction

  // one random phase; a share of matched indices and cosines near the thresholds
  task automatic fill_random(input int n);
    req_t rq;
    for (int i = 0; i < n; i++) begin
      rq = make_req(rand_index(), rand_index(), rand_cos());
      if ($urandom_range(0, 15) == 0) rq.index_transmit = rq.index_incident;
      if ($urandom_range(0, 15) == 0)
        rq.cos_incident = thr_normal + COS_W'($urandom_range(0, 2)) - COS_W'(1);
      if ($urandom_range(0, 15) == 0)
        rq.cos_incident = thr_grazing + COS_W'($urandom_range(0, 2)) - COS_W'(1);
      request_q.push_back(rq);
    end
  endtask

  initial begin
    thr_normal = NORMAL_THR_RESET;
    thr_grazing = GRAZING_THR_RESET;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: each case, field extremes, cosine above one
    request_q.push_back(make_req(18'd65536, 18'd65536, 31'd0));
    request_q.push_back(make_req(18'd262143, 18'd262143, 31'h7FFF_FFFF));
    request_q.push_back(make_req(18'd65536, 18'd262143, COS_ONE));
    request_q.push_back(make_req(18'd262143, 18'd65536, COS_ONE));
    request_q.push_back(make_req(18'd65536, 18'd98304, 31'h7FFF_FFFF));
    request_q.push_back(make_req(18'd65536, 18'd98304, 31'd0));
    request_q.push_back(make_req(18'd65536, 18'd98304, 31'd1073));
    request_q.push_back(make_req(18'd65536, 18'd98304, 31'd1074));
    request_q.push_back(make_req(18'd98304, 18'd65536, 31'd100000000));
    request_q.push_back(make_req(18'd98304, 18'd65536, 31'd900000000));
    request_q.push_back(make_req(18'd262143, 18'd65536, 31'd536870912));
    request_q.push_back(make_req(18'd65536, 18'd262143, 31'd536870912));
    request_q.push_back(make_req(18'd65537, 18'd65536, 31'd1073741822));
    request_q.push_back(make_req(18'd65536, 18'd65537, 31'd1073741823));
    request_q.push_back(make_req(18'd87381, 18'd65536, 31'd759250125));
    fill_random(N_RANDOM / 4);
    wait_idle();

    // extremes: no normal case, grazing takes every unmatched request below one
    apb_write(REG_NORMAL, COS_ONE);
    apb_write(REG_GRAZING, COS_ONE);
    fill_random(N_RANDOM / 8);
    wait_idle();

    apb_write(REG_NORMAL, '0);
    apb_write(REG_GRAZING, '0);
    fill_random(N_RANDOM / 8);
    wait_idle();

    apb_write(REG_NORMAL, COS_W'($urandom_range(600000000, 1073741824)));
    apb_write(REG_GRAZING, COS_W'($urandom_range(0, 400000000)));
    fill_random(N_RANDOM / 4);
    wait_idle();

    apb_write(REG_NORMAL, NORMAL_THR_RESET);
    apb_write(REG_GRAZING, GRAZING_THR_RESET);
    fill_random(N_RANDOM / 4);
    wait_idle();

    if (fail_count == 0 && expected_q.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/frr_pkg.sv
rtl/frr_datapath.sv
rtl/fresnel_reflectance_top.sv
tb/sv/tb_fresnel_reflectance_top.sv
